FILE: rtl/core/adjacency_matrix_dfs_assert.svh
// Concurrent assertion macros, sampled on clk and disabled while rst_n is low.
`ifndef ADJACENCY_MATRIX_DFS_ASSERT_SVH
`define ADJACENCY_MATRIX_DFS_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define AMD_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define AMD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define AMD_ASSERT_IMPL(name, ante, cons, msg)
`define AMD_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

FILE: rtl/core/amd_pkg.sv
`default_nettype none

package amd_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int RESULT_LIMIT     = 16;

    localparam int CFG_W   = 5;
    localparam int IDX_W   = 4;
    localparam int LABEL_W = 8;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 5'd16;

    typedef enum logic [1:0] {
        OP_SET_LABEL = 2'd0,
        OP_ADD_EDGE  = 2'd1,
        OP_TRAVERSE  = 2'd2,
        OP_CLEAR     = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK           = 2'd0,
        ST_NOT_FOUND    = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic {
        KIND_STATUS = 1'b0,
        KIND_VERTEX = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        status_t            status;
        logic [IDX_W-1:0]   vertex_index;
        logic [LABEL_W-1:0] vertex_label;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/adjacency_matrix_dfs.sv
// Channel   Dir  Signals                        Contents (lowest bit up)
// s_*       in   tvalid tready tdata[23:0] tuser  tdata: index, label_a, label_b; tuser: op
// m_*       out  tvalid tready tdata[15:0] tuser  tdata: status, vertex_index, vertex_label
//                tlast                            tuser: kind; tlast: last
// cfg_*     in   we wdata[4:0]                    vertex_count
//
// Add edge first looks up both labels over the n vertices in use, then writes the edge;
// a missing label skips the write. A traversal steps through START, SCAN and FLUSH, an
// out of range one goes straight to the response; one shared scan step walks one
// adjacency column per cycle, except while a hit waits on a full result register.
// s_tready is high only while idle; a full result register stalls the scan.
// Reset clears labels, edges and control state at once; no clearing pass.
`default_nettype none

`include "adjacency_matrix_dfs_assert.svh"

module adjacency_matrix_dfs
    import amd_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // index, label_a, label_b, zero pad
    input  wire logic [1:0]            s_tuser,   // op
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // status, vertex_index, vertex_label, pad
    output logic                       m_tuser,   // kind
    output logic                       m_tlast,   // last
    input  wire logic                  cfg_we,
    input  wire logic [CFG_W-1:0]      cfg_wdata  // vertex_count
);

    localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int KW   = $clog2(MAX_VERTICES + 1);
    localparam int CMPW = (KW > CFG_W) ? KW : CFG_W;

    typedef enum logic [2:0] {
        IDLE,
        LOOKUP,
        EDGE,
        START,
        SCAN,
        FLUSH,
        RESP
    } state_t;

    typedef struct packed {
        logic [VW-1:0] vertex;
        logic [KW-1:0] scan;
    } stack_entry_t;

    state_t                 state_reg;
    logic [CFG_W-1:0]       vertex_count_reg;
    logic [LABEL_W-1:0]     labels_reg [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_reg   [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] visited_reg;
    stack_entry_t           stack_reg  [MAX_VERTICES];
    logic [KW-1:0]          depth_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [KW-1:0]          k_reg;
    logic [VW-1:0]          v_reg;
    logic                   fa_reg;
    logic                   fb_reg;
    logic [VW-1:0]          i_reg;
    logic [VW-1:0]          j_reg;
    status_t                status_reg;
    logic [IDX_W-1:0]       pend_idx_reg;
    logic [LABEL_W-1:0]     pend_lab_reg;
    logic [LABEL_W-1:0]     la_reg;
    logic [LABEL_W-1:0]     lb_reg;

    logic [IDX_W-1:0]   in_index;
    logic [LABEL_W-1:0] in_label_a;
    logic [LABEL_W-1:0] in_label_b;
    op_t                in_op;
    logic [CMPW-1:0]    n_ext;
    logic [CMPW-1:0]    vc_ext;
    logic [CMPW-1:0]    max_ext;
    logic               idx_ge_n;
    logic               k_done;
    logic [VW-1:0]      kv;
    logic [VW-1:0]      idx_v;
    logic [LABEL_W-1:0] lab_rd;
    logic               hit;
    logic               scan_live;
    stack_entry_t       stack_rd;
    logic               push_ok;
    logic               res_valid;
    logic               res_ready;
    logic               res_push;
    result_t            res_data;
    result_t            out_data;

    assign in_index   = s_tdata[IDX_W-1:0];
    assign in_label_a = s_tdata[IDX_W+LABEL_W-1:IDX_W];
    assign in_label_b = s_tdata[IDX_W+2*LABEL_W-1:IDX_W+LABEL_W];
    assign in_op      = op_t'(s_tuser);

    assign vc_ext   = CMPW'(vertex_count_reg);
    assign max_ext  = CMPW'(MAX_VERTICES);
    assign n_ext    = (vc_ext < max_ext) ? vc_ext : max_ext;
    assign idx_ge_n = CMPW'(in_index) >= n_ext;
    assign k_done   = CMPW'(k_reg) >= n_ext;
    assign kv       = k_reg[VW-1:0];
    assign idx_v    = VW'(in_index);

    assign lab_rd    = labels_reg[kv];
    assign hit       = adj_reg[v_reg][kv] && !visited_reg[kv];
    assign scan_live = (depth_reg != '0) && (cnt_reg < CNT_W'(RESULT_LIMIT));
    assign stack_rd  = stack_reg[VW'(depth_reg - KW'(2))];
    assign push_ok   = depth_reg < KW'(MAX_VERTICES);

    assign s_tready = (state_reg == IDLE);

    always_comb
    begin
        res_valid = 1'b0;
        res_data  = '{kind: KIND_STATUS, status: status_reg, vertex_index: '0,
                      vertex_label: '0, last: 1'b1};
        unique case (state_reg)
            RESP:
            begin
                res_valid = 1'b1;
            end
            FLUSH:
            begin
                res_valid = 1'b1;
                res_data  = '{kind: KIND_VERTEX, status: ST_OK, vertex_index: pend_idx_reg,
                              vertex_label: pend_lab_reg, last: 1'b1};
            end
            SCAN:
            begin
                res_valid = scan_live && !k_done && hit;
                res_data  = '{kind: KIND_VERTEX, status: ST_OK, vertex_index: pend_idx_reg,
                              vertex_label: pend_lab_reg, last: 1'b0};
            end
            IDLE, LOOKUP, EDGE, START:
            begin
                res_valid = 1'b0;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    assign res_push = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= IDLE;
            vertex_count_reg <= VERTEX_COUNT_RESET;
            for (int r = 0; r < MAX_VERTICES; r++)
            begin
                labels_reg[r] <= '0;
                adj_reg[r]    <= '0;
            end
            visited_reg  <= '0;
            depth_reg    <= '0;
            cnt_reg      <= '0;
            k_reg        <= '0;
            v_reg        <= '0;
            fa_reg       <= 1'b0;
            fb_reg       <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            status_reg   <= ST_OK;
            pend_idx_reg <= '0;
            pend_lab_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                vertex_count_reg <= cfg_wdata;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        unique case (in_op)
                            OP_SET_LABEL:
                            begin
                                if (idx_ge_n)
                                begin
                                    status_reg <= ST_OUT_OF_RANGE;
                                end
                                else
                                begin
                                    labels_reg[idx_v] <= in_label_a;
                                    status_reg        <= ST_OK;
                                end
                                state_reg <= RESP;
                            end
                            OP_ADD_EDGE:
                            begin
                                k_reg     <= '0;
                                fa_reg    <= 1'b0;
                                fb_reg    <= 1'b0;
                                state_reg <= LOOKUP;
                            end
                            OP_TRAVERSE:
                            begin
                                if (idx_ge_n)
                                begin
                                    status_reg <= ST_OUT_OF_RANGE;
                                    state_reg  <= RESP;
                                end
                                else
                                begin
                                    k_reg       <= KW'(in_index);
                                    visited_reg <= MAX_VERTICES'(1) << idx_v;
                                    cnt_reg     <= CNT_W'(1);
                                    state_reg   <= START;
                                end
                            end
                            OP_CLEAR:
                            begin
                                for (int r = 0; r < MAX_VERTICES; r++)
                                begin
                                    adj_reg[r] <= '0;
                                end
                                status_reg <= ST_OK;
                                state_reg  <= RESP;
                            end
                            default:
                            begin
                                state_reg <= IDLE;
                            end
                        endcase
                    end
                end
                LOOKUP:
                begin
                    if (k_done)
                    begin
                        if (fa_reg && fb_reg)
                        begin
                            state_reg <= EDGE;
                        end
                        else
                        begin
                            status_reg <= ST_NOT_FOUND;
                            state_reg  <= RESP;
                        end
                    end
                    else
                    begin
                        if (!fa_reg && (lab_rd == la_reg))
                        begin
                            fa_reg <= 1'b1;
                            i_reg  <= kv;
                        end
                        if (!fb_reg && (lab_rd == lb_reg))
                        begin
                            fb_reg <= 1'b1;
                            j_reg  <= kv;
                        end
                        k_reg <= k_reg + KW'(1);
                    end
                end
                EDGE:
                begin
                    adj_reg[i_reg][j_reg] <= 1'b1;
                    adj_reg[j_reg][i_reg] <= 1'b1;
                    status_reg            <= ST_OK;
                    state_reg             <= RESP;
                end
                START:
                begin
                    pend_idx_reg <= IDX_W'(k_reg);
                    pend_lab_reg <= lab_rd;
                    v_reg        <= kv;
                    k_reg        <= '0;
                    depth_reg    <= KW'(1);
                    state_reg    <= SCAN;
                end
                SCAN:
                begin
                    priority if (!scan_live)
                    begin
                        state_reg <= FLUSH;
                    end
                    else if (k_done)
                    begin
                        depth_reg <= depth_reg - KW'(1);
                        if (depth_reg > KW'(1))
                        begin
                            v_reg <= stack_rd.vertex;
                            k_reg <= stack_rd.scan;
                        end
                    end
                    else if (hit)
                    begin
                        if (res_ready)
                        begin
                            pend_idx_reg     <= IDX_W'(k_reg);
                            pend_lab_reg     <= lab_rd;
                            visited_reg[kv]  <= 1'b1;
                            cnt_reg          <= cnt_reg + CNT_W'(1);
                            if (push_ok)
                            begin
                                depth_reg <= depth_reg + KW'(1);
                                v_reg     <= kv;
                                k_reg     <= '0;
                            end
                            else
                            begin
                                k_reg <= k_reg + KW'(1);
                            end
                        end
                    end
                    else
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                FLUSH:
                begin
                    if (res_ready)
                    begin
                        depth_reg <= '0;
                        state_reg <= IDLE;
                    end
                end
                RESP:
                begin
                    if (res_ready)
                    begin
                        state_reg <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    // Latch labels on accept; save the top with its advanced scan before descending.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            la_reg <= in_label_a;
            lb_reg <= in_label_b;
        end
        if ((state_reg == SCAN) && res_push && push_ok)
        begin
            stack_reg[VW'(depth_reg - KW'(1))] <= '{vertex: v_reg, scan: k_reg + KW'(1)};
        end
    end

    amd_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (res_valid),
        .in_ready (res_ready),
        .in_data  (res_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .out_data (out_data)
    );

    assign m_tdata = {{(OUT_DATA_W - STAT_W - IDX_W - LABEL_W){1'b0}},
                      out_data.vertex_label, out_data.vertex_index, out_data.status};
    assign m_tuser = out_data.kind;
    assign m_tlast = out_data.last;

    `AMD_ASSERT_IMPL(a_idle_stack_empty, s_tready, depth_reg == '0,
        "stack not empty while idle")
    `AMD_ASSERT_IMPL(a_visit_count, 1'b1, $countones(visited_reg) == int'(cnt_reg),
        "visited bits disagree with visit count")
    `AMD_ASSERT_IMPL(a_cnt_limit, 1'b1, cnt_reg <= CNT_W'(RESULT_LIMIT),
        "visit count above result limit")
    `AMD_ASSERT_NEXT(a_flush_done, (state_reg == FLUSH) && res_ready,
        s_tready && m_tvalid && m_tlast, "final result not registered after flush")

endmodule

`default_nettype wire

FILE: rtl/core/amd_out_reg.sv
`default_nettype none

module amd_out_reg
    import amd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_data,
    output logic         m_tvalid,
    input  wire logic    m_tready,
    output result_t      out_data
);

    logic    valid_reg;
    result_t data_reg;

    assign in_ready = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign out_data = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire
